### rtl/core/bwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_pkg
// Shared types, codes and constants of the breadcrumb waypoint return block.
// ----------------------------------------------------------------------------
package bwr_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_POSE       = 2'd0,
    CMD_PUSH       = 2'd1,
    CMD_PUSH_SOUND = 2'd2,
    CMD_RETURN     = 2'd3
  } cmd_code_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_POP     = 2'd0,
    EV_STEER   = 2'd1,
    EV_PUSHED  = 2'd2,
    EV_DROPPED = 2'd3
  } event_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_MULT,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_HEAD,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic set_return;
    logic push;
    logic mult;
    logic cordic_init;
    logic cordic_step;
    logic heading;
    logic sq_x;
    logic sq_y;
    logic sum;
    logic sqrt_step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic report;
    logic cordic_last;
    logic sqrt_last;
  } dp_status_t;

  localparam int unsigned CORDIC_ITERS  = 18;
  localparam int unsigned SQRT_ITERS    = 26;
  localparam logic [8:0]  HEADING_RESET = 9'd180;
  localparam logic [15:0] RADIUS_RESET  = 16'd102;
  localparam logic signed [25:0] DEG90  = 26'sd5898240;
  // 180 degrees plus the 1/256 degree bias, units of 2^-16 degree
  localparam logic signed [25:0] HEAD_BIAS = 26'sd11796736;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [25:0] atan_lut(input logic [4:0] i);
    logic signed [25:0] r;
    begin
      case (i)
        5'd0:    r = 26'sd2949120;
        5'd1:    r = 26'sd1740967;
        5'd2:    r = 26'sd919879;
        5'd3:    r = 26'sd466945;
        5'd4:    r = 26'sd234379;
        5'd5:    r = 26'sd117304;
        5'd6:    r = 26'sd58666;
        5'd7:    r = 26'sd29335;
        5'd8:    r = 26'sd14668;
        5'd9:    r = 26'sd7334;
        5'd10:   r = 26'sd3667;
        5'd11:   r = 26'sd1833;
        5'd12:   r = 26'sd917;
        5'd13:   r = 26'sd458;
        5'd14:   r = 26'sd229;
        5'd15:   r = 26'sd115;
        5'd16:   r = 26'sd57;
        5'd17:   r = 26'sd29;
        default: r = 26'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/core/breadcrumb_waypoint_return.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breadcrumb_waypoint_return
// Waypoint stack with return-mode steering reports.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command, tdata the pose. Pose updates keep
// the latest position and heading; push commands store that pose on the
// waypoint stack; start-return enables return mode. Output stream: tuser
// carries the event kind, tdata the sound cue, heading delta and distance.
// The cfg channel writes the arrival radius (ready always high).
// Throughput: one item at a time. A pose update runs the 18-step CORDIC
// heading loop and, when it reports, the 26-step bit-serial square root;
// the two share one iteration counter. The result sits in an output
// register, so the next item is accepted while it waits; if the receiver
// stalls, a later item that produces a result waits in its final state until
// the register is free.
// Reset (rst, synchronous) empties the stack, leaves return mode, sets the
// pose to origin with heading 180 and the radius to 102.
// ----------------------------------------------------------------------------
module breadcrumb_waypoint_return #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // pos_x, pos_y, quat_w, quat_z
  input  logic [1:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // sound_cue, delta_heading, distance, pad
  output logic [1:0]  m_axis_tuser,  // event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data       // arrive_radius
);

  bwr_pkg::dp_cmd_t    cmd;
  bwr_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  bwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  bwr_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_cmd    (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

endmodule

### rtl/core/bwr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bwr_ram #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/bwr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_ctrl
// Sequencer: steps the datapath through heading, distance and stack updates.
// ----------------------------------------------------------------------------
module bwr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  bwr_pkg::dp_status_t status,
  output bwr_pkg::dp_cmd_t    cmd
);

  bwr_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      bwr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (bwr_pkg::cmd_code_t'(in_cmd))
            bwr_pkg::CMD_RETURN: cmd.set_return = 1'b1;
            bwr_pkg::CMD_POSE:   state_next = bwr_pkg::ST_MULT;
            default:             state_next = bwr_pkg::ST_PUSH;
          endcase
        end
      end
      bwr_pkg::ST_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = bwr_pkg::ST_IDLE;
        end
      end
      bwr_pkg::ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = bwr_pkg::ST_CORDIC_INIT;
      end
      bwr_pkg::ST_CORDIC_INIT: begin
        cmd.cordic_init = 1'b1;
        state_next      = bwr_pkg::ST_CORDIC;
      end
      bwr_pkg::ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_last) begin
          state_next = bwr_pkg::ST_HEAD;
        end
      end
      bwr_pkg::ST_HEAD: begin
        cmd.heading = 1'b1;
        state_next  = status.report ? bwr_pkg::ST_SQX : bwr_pkg::ST_IDLE;
      end
      bwr_pkg::ST_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = bwr_pkg::ST_SQY;
      end
      bwr_pkg::ST_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = bwr_pkg::ST_SUM;
      end
      bwr_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = bwr_pkg::ST_SQRT;
      end
      bwr_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last) begin
          state_next = bwr_pkg::ST_EMIT;
        end
      end
      bwr_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = bwr_pkg::ST_IDLE;
        end
      end
      default: state_next = bwr_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/core/bwr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_dp
// Datapath: pose registers, CORDIC heading, waypoint stack, distance unit
// and the output register.
// ----------------------------------------------------------------------------
module bwr_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  bwr_pkg::dp_cmd_t    cmd,
  output bwr_pkg::dp_status_t status,
  input  logic [1:0]          in_cmd,
  input  logic [79:0]         in_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [39:0]         out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int RW = 58;

  // Latched input fields
  logic signed [23:0] in_x, in_y;
  logic signed [15:0] in_w, in_z;
  logic               push_sound;

  // Architectural state
  logic [CW-1:0]  count;
  logic           return_mode;
  logic [23:0]    last_x, last_y;
  logic [8:0]     last_heading;
  logic [15:0]    radius;

  // Working registers
  logic signed [33:0] s_val, c_val, cx, cy;
  logic signed [25:0] acc;
  logic [4:0]         iter;
  logic signed [24:0] dx, dy;
  logic [49:0]        px, py;
  logic [31:0]        r2;
  logic               arrive;
  logic [9:0]         dh;
  logic [51:0]        sq_v;
  logic [27:0]        rem;
  logic [25:0]        root;

  // Stack memory
  logic [RW-1:0] rd_word, wr_word;
  logic          full, ram_we;
  logic [AW-1:0] top_addr;

  assign full     = (count == CW'(STACK_DEPTH));
  assign ram_we   = cmd.push && !full;
  assign top_addr = AW'(count - CW'(1));
  assign wr_word  = {push_sound, last_heading, last_y, last_x};

  bwr_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_word),
    .rd_addr (top_addr),
    .rd_data (rd_word)
  );

  logic [23:0] top_x, top_y;
  logic [8:0]  top_heading;
  logic        top_sound;
  assign top_x       = rd_word[23:0];
  assign top_y       = rd_word[47:24];
  assign top_heading = rd_word[56:48];
  assign top_sound   = rd_word[57];

  // Quaternion products
  logic signed [31:0] prod_wz, prod_zz;
  assign prod_wz = in_w * in_z;
  assign prod_zz = in_z * in_z;

  // CORDIC step terms
  logic signed [33:0] xs, ys;
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;

  // Heading rounding and wrap
  logic signed [25:0] head_sum;
  logic signed [10:0] head_raw, head_wrap;
  assign head_sum = acc + bwr_pkg::HEAD_BIAS;
  assign head_raw = 11'($signed(head_sum[25:16]));
  always_comb begin
    if (head_raw < 11'sd0) begin
      head_wrap = head_raw + 11'sd360;
    end else if (head_raw >= 11'sd360) begin
      head_wrap = head_raw - 11'sd360;
    end else begin
      head_wrap = head_raw;
    end
  end

  // Squares and sum
  logic signed [49:0] dx_sq, dy_sq;
  logic [50:0]        sq_sum;
  assign dx_sq  = dx * dx;
  assign dy_sq  = dy * dy;
  assign sq_sum = {1'b0, px} + {1'b0, py};

  // Square root trial
  logic [27:0] rem_sh, trial;
  assign rem_sh = {rem[25:0], sq_v[51:50]};
  assign trial  = {root, 2'b01};

  // Status to controller
  assign status.out_free    = !out_valid || out_ready;
  assign status.report      = return_mode && (count != '0);
  assign status.cordic_last = (iter == 5'(bwr_pkg::CORDIC_ITERS - 1));
  assign status.sqrt_last   = (iter == 5'(bwr_pkg::SQRT_ITERS - 1));

  // Control state: stack count, mode, radius, last pose, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      return_mode  <= 1'b0;
      radius       <= bwr_pkg::RADIUS_RESET;
      last_x       <= '0;
      last_y       <= '0;
      last_heading <= bwr_pkg::HEADING_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius <= cfg_data;
      end
      if (cmd.set_return) begin
        return_mode <= 1'b1;
      end
      if (ram_we) begin
        count <= count + CW'(1);
      end else if (cmd.emit && arrive) begin
        count <= count - CW'(1);
      end
      if (cmd.heading) begin
        last_x       <= in_x;
        last_y       <= in_y;
        last_heading <= head_wrap[8:0];
      end
      if (cmd.push || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_x       <= in_data[23:0];
      in_y       <= in_data[47:24];
      in_w       <= in_data[63:48];
      in_z       <= in_data[79:64];
      push_sound <= (bwr_pkg::cmd_code_t'(in_cmd) == bwr_pkg::CMD_PUSH_SOUND);
    end
    if (cmd.mult) begin
      s_val <= {prod_wz[31], prod_wz, 1'b0};
      c_val <= 34'sh1000_0000 - {prod_zz[31], prod_zz, 1'b0};
    end
    // Pre-rotate into the right half plane
    if (cmd.cordic_init) begin
      iter <= '0;
      if (c_val < 0) begin
        if (s_val >= 0) begin
          cx  <= s_val;
          cy  <= -c_val;
          acc <= bwr_pkg::DEG90;
        end else begin
          cx  <= -s_val;
          cy  <= c_val;
          acc <= -bwr_pkg::DEG90;
        end
      end else begin
        cx  <= c_val;
        cy  <= s_val;
        acc <= '0;
      end
    end
    // Rotate toward the x axis
    if (cmd.cordic_step) begin
      iter <= iter + 5'd1;
      if (cy >= 0) begin
        cx  <= cx + ys;
        cy  <= cy - xs;
        acc <= acc + bwr_pkg::atan_lut(iter);
      end else begin
        cx  <= cx - ys;
        cy  <= cy + xs;
        acc <= acc - bwr_pkg::atan_lut(iter);
      end
    end
    if (cmd.heading) begin
      dx <= {top_x[23], top_x} - {in_x[23], in_x};
      dy <= {top_y[23], top_y} - {in_y[23], in_y};
    end
    if (cmd.sq_x) begin
      px <= dx_sq;
      r2 <= radius * radius;
    end
    if (cmd.sq_y) begin
      py <= dy_sq;
    end
    if (cmd.sum) begin
      arrive <= (sq_sum <= {19'd0, r2});
      dh     <= {1'b0, top_heading} - {1'b0, last_heading};
      sq_v   <= {1'b0, sq_sum};
      rem    <= '0;
      root   <= '0;
      iter   <= '0;
    end
    // One result bit per cycle
    if (cmd.sqrt_step) begin
      iter <= iter + 5'd1;
      sq_v <= {sq_v[49:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[24:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[24:0], 1'b0};
      end
    end
    // Load the output register
    if (cmd.push) begin
      out_kind <= full ? bwr_pkg::EV_DROPPED : bwr_pkg::EV_PUSHED;
      out_data <= '0;
    end else if (cmd.emit) begin
      out_kind <= arrive ? bwr_pkg::EV_POP : bwr_pkg::EV_STEER;
      out_data <= {4'd0, root[24:0], dh, arrive & top_sound};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> count == $past(count) + CW'(1))
    else $error("push did not advance stack count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && arrive) |=> count == $past(count) - CW'(1))
    else $error("pop did not drop stack count");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    last_heading < 9'd360)
    else $error("heading out of range");
`endif

endmodule

### sim/breadcrumb_waypoint_return_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breadcrumb_waypoint_return_tb
// Self-checking bench for the waypoint stack and its return-mode reports.
// A queue of commands feeds a stream driver. A bit-exact heading and distance
// model predicts each report. A monitor compares every output transfer with
// the oldest prediction. Phases vary the radius and the idling on both sides.
// ----------------------------------------------------------------------------
module breadcrumb_waypoint_return_tb;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    bwr_pkg::cmd_code_t cmd;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [15:0] qw;
    logic signed [15:0] qz;
  } pose_cmd_t;

  typedef struct packed {
    bwr_pkg::event_t    kind;
    logic               cue;
    logic signed [9:0]  dhead;
    logic [24:0]        span;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  breadcrumb_waypoint_return #(.STACK_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic signed [23:0] wp_x [DEPTH];
  logic signed [23:0] wp_y [DEPTH];
  int                 wp_head [DEPTH];
  logic               wp_cue [DEPTH];
  int                 wp_count;
  logic               returning;
  logic signed [23:0] cur_x, cur_y;
  int                 cur_head;
  logic [15:0]        radius;

  pose_cmd_t pending_cmds[$];
  report_t   expected_reports[$];
  pose_cmd_t offered;
  int        send_idle_pct, recv_idle_pct;
  bit        recv_hold;
  int        hold_cycles;
  int        errors;
  int        cycles;

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  // Vectoring CORDIC heading in whole degrees, 0..359
  function automatic int quat_heading(longint w, longint z);
    longint x, y, acc, t, xs, ys, h;
    longint angles [18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115, 57, 29};
    y = 2 * w * z;
    x = (64'sd1 <<< 28) - 2 * z * z;
    acc = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < 18; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc += angles[i];
      end else begin
        x = x - ys; y = y + xs; acc -= angles[i];
      end
    end
    h = fshift(acc + 180 * 65536 + 256, 16);
    while (h < 0) h += 360;
    while (h >= 360) h -= 360;
    return int'(h);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Append a command to the pending queue
  task automatic queue_item(input pose_cmd_t p);
    pending_cmds.insert(pending_cmds.size(), p);
  endtask

  // Append a prediction to the expected queue
  task automatic expect_report(input report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endtask

  // Advance the predictor by one accepted command
  task automatic predict_waypoint(input pose_cmd_t c);
    report_t rep;
    longint dx, dy;
    longint unsigned sq, r2;
    int t;
    rep = '0;
    case (c.cmd)
      bwr_pkg::CMD_RETURN: returning = 1'b1;
      bwr_pkg::CMD_PUSH, bwr_pkg::CMD_PUSH_SOUND: begin
        if (wp_count >= DEPTH) begin
          rep.kind = bwr_pkg::EV_DROPPED;
        end else begin
          wp_x[wp_count] = cur_x;
          wp_y[wp_count] = cur_y;
          wp_head[wp_count] = cur_head;
          wp_cue[wp_count] = (c.cmd == bwr_pkg::CMD_PUSH_SOUND);
          wp_count++;
          rep.kind = bwr_pkg::EV_PUSHED;
        end
        expect_report(rep);
      end
      default: begin
        cur_x = c.px;
        cur_y = c.py;
        cur_head = quat_heading(c.qw, c.qz);
        if (returning && wp_count > 0) begin
          t = wp_count - 1;
          dx = longint'(wp_x[t]) - longint'(cur_x);
          dy = longint'(wp_y[t]) - longint'(cur_y);
          sq = longint'(dx * dx) + longint'(dy * dy);
          r2 = longint'(radius) * longint'(radius);
          rep.dhead = 10'(wp_head[t] - cur_head);
          rep.span = 25'(int_sqrt(sq));
          if (sq <= r2) begin
            rep.kind = bwr_pkg::EV_POP;
            rep.cue = wp_cue[t];
            wp_count = t;
          end else begin
            rep.kind = bwr_pkg::EV_STEER;
          end
          expect_report(rep);
        end
      end
    endcase
  endtask

  // Stream driver: offer queued commands, idle at random
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) predict_waypoint(offered);
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_cmds[0].cmd;
          s_axis_tdata <= {pending_cmds[0].qz, pending_cmds[0].qw,
                           pending_cmds[0].py, pending_cmds[0].px};
          offered <= pending_cmds[0];
          void'(pending_cmds.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, with a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (recv_hold && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    report_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {bwr_pkg::event_t'(m_axis_tuser), m_axis_tdata[0], m_axis_tdata[10:1],
             m_axis_tdata[35:11]};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got.kind != want.kind || got.cue != want.cue ||
            got.dhead != want.dhead || got.span != want.span) begin
          $display("%0t: mismatch, expected kind %0d cue %0d dh %0d dist %0d,",
                   $time, want.kind, want.cue, want.dhead, want.span);
          $display("    actual kind %0d cue %0d dh %0d dist %0d",
                   got.kind, got.cue, got.dhead, got.span);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic pose_cmd_t make_pose(logic signed [23:0] x, logic signed [23:0] y,
                                          logic signed [15:0] w, logic signed [15:0] z);
    return {bwr_pkg::CMD_POSE, x, y, w, z};
  endfunction

  function automatic pose_cmd_t make_cmd(bwr_pkg::cmd_code_t c);
    pose_cmd_t p;
    p = '0;
    p.cmd = c;
    p.px = 24'($urandom);
    p.py = 24'($urandom);
    p.qw = 16'($urandom);
    p.qz = 16'($urandom);
    return p;
  endfunction

  // Random unit-ish quaternion, including the extremes
  function automatic pose_cmd_t rand_pose(int spread);
    pose_cmd_t p;
    p.cmd = bwr_pkg::CMD_POSE;
    p.px = 24'($signed(24'($urandom_range(2 * spread))) - spread);
    p.py = 24'($signed(24'($urandom_range(2 * spread))) - spread);
    p.qw = 16'($signed($urandom_range(32768)) - 16384);
    p.qz = 16'($signed($urandom_range(32768)) - 16384);
    return p;
  endfunction

  task automatic drain_and_settle();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_radius(input logic [15:0] r);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius = r;
    cfg_valid <= 1'b0;
  endtask

  // One trip: pushes along a path, then walk back with noise
  task automatic queue_trip(input int spread, input int near);
    int n;
    pose_cmd_t p;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      p = rand_pose(spread);
      queue_item(p);
      queue_item(make_cmd($urandom_range(1) ? bwr_pkg::CMD_PUSH : bwr_pkg::CMD_PUSH_SOUND));
    end
    queue_item(make_cmd(bwr_pkg::CMD_RETURN));
    for (int i = 0; i < 2 * n + 2; i++) begin
      if ($urandom_range(3) == 0) p = rand_pose(spread);
      else begin
        p.px = 24'(p.px + $signed(24'($urandom_range(2 * near))) - near);
        p.py = 24'(p.py + $signed(24'($urandom_range(2 * near))) - near);
        p.qw = 16'($signed($urandom_range(32768)) - 16384);
        p.qz = 16'($signed($urandom_range(32768)) - 16384);
      end
      queue_item(p);
    end
  endtask

  initial begin
    wp_count = 0;
    returning = 1'b0;
    cur_x = '0;
    cur_y = '0;
    cur_head = 180;
    radius = bwr_pkg::RADIUS_RESET;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    hold_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity heading, axis quaternions, field extremes
    queue_item(make_cmd(bwr_pkg::CMD_PUSH));
    queue_item(make_pose(24'sd0, 24'sd0, 16'sd16384, 16'sd0));
    queue_item(make_pose(24'sh7FFFFF, 24'sh800000, 16'sd0, 16'sd16384));
    queue_item(make_pose(24'sh800000, 24'sh7FFFFF, 16'sd11585, 16'sd11585));
    queue_item(make_pose(24'sh800000, 24'sh800000, -16'sd11585, 16'sd11585));
    queue_item(make_pose(24'sh7FFFFF, 24'sh7FFFFF, -16'sd16384, -16'sd16384));
    queue_item(make_cmd(bwr_pkg::CMD_PUSH_SOUND));
    queue_item(make_pose(24'sh800000, 24'sh800000, 16'sd0, -16'sd16384));
    queue_item(make_cmd(bwr_pkg::CMD_PUSH));
    queue_item(make_cmd(bwr_pkg::CMD_RETURN));
    queue_item(make_cmd(bwr_pkg::CMD_RETURN));
    queue_item(make_pose(24'sh7FFFFF, 24'sh7FFFFF, 16'sd16384, 16'sd0));
    queue_item(make_pose(24'sh800000, 24'sh800000, 16'sd16384, 16'sd0));
    queue_item(make_pose(24'sd50, -24'sd60, 16'sd16384, 16'sd0));
    queue_item(make_pose(24'sd0, 24'sd0, -16'sd16384, 16'sd1));
    queue_item(make_pose(24'sd0, 24'sd0, 16'sd0, 16'sd0));
    drain_and_settle();

    // Fill the stack past full with the receiver held off
    write_radius(16'd0);
    recv_hold = 1'b1;
    for (int i = 0; i < DEPTH + 3; i++)
      queue_item(make_cmd($urandom_range(1) ? bwr_pkg::CMD_PUSH_SOUND : bwr_pkg::CMD_PUSH));
    drain_and_settle();
    recv_hold = 1'b0;

    // Empty the stack, popping at the widest radius
    write_radius(16'hFFFF);
    for (int i = 0; i < DEPTH + 2; i++)
      queue_item(rand_pose(30000));
    drain_and_settle();

    // Random trips over several idling and radius settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  write_radius(16'd102); end
        1: begin send_idle_pct = 61; recv_idle_pct = 0;  write_radius(16'd3000); end
        2: begin send_idle_pct = 0;  recv_idle_pct = 61; write_radius(16'd1); end
        default: begin send_idle_pct = 33; recv_idle_pct = 33; write_radius(16'd65535); end
      endcase
      while (pending_cmds.size() < 120) begin
        if ($urandom_range(9) == 0)
          queue_item(make_cmd(bwr_pkg::cmd_code_t'($urandom_range(3))));
        else
          queue_trip($urandom_range(1) ? 8388607 : 20000, ph == 2 ? 2 : 400);
      end
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
